// ===== rtl/core/mafs_pkg.sv =====
// Shared constants, lookup tables and types for the MPEG audio frame scanner.
`default_nettype none
package mafs_pkg;

   localparam int FRAME_COUNT_BITS = 24;
   localparam int BITRATE_BITS     = 19;
   localparam int RATE_BITS        = 16;
   localparam int SKIP_BITS        = 12;
   localparam int SIZE_BITS        = 32;
   localparam int OUT_COUNT_BITS   = 24;
   localparam int SUM_BITS         = FRAME_COUNT_BITS + BITRATE_BITS;
   localparam int DVD_BITS         = (SUM_BITS > SIZE_BITS) ? SUM_BITS : SIZE_BITS;
   localparam int DVS_BITS         = (FRAME_COUNT_BITS > BITRATE_BITS) ?
                                     FRAME_COUNT_BITS : BITRATE_BITS;
   localparam int CNT_BITS         = $clog2(DVD_BITS);
   localparam int KBPS_BITS        = 9;

   localparam logic [11:0] SYNC_MARK         = 12'hFFF;
   localparam int unsigned BPS_SCALE         = 1000;
   localparam int unsigned FRAME_BYTES_SCALE = 144000;
   localparam logic [1:0]  MODE_MONO         = 2'b11;
   localparam logic [3:0]  BRI_FREE          = 4'h0;
   localparam logic [3:0]  BRI_BAD           = 4'hF;
   localparam logic [1:0]  RI_BAD            = 2'd3;
   localparam logic [1:0]  LAYER_NONE        = 2'b00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FDIV,
      ST_AVG,
      ST_LEN,
      ST_EMIT
   } state_type;

   typedef logic [KBPS_BITS-1:0] kbps_row_type [16];

   localparam kbps_row_type KBPS_ZERO = '{default: 9'd0};
   localparam kbps_row_type KBPS_V2   = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48,
      9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
   localparam kbps_row_type KBPS_V2L1 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam kbps_row_type KBPS_L3   = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
      9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam kbps_row_type KBPS_L2   = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam kbps_row_type KBPS_L1   = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192,
      9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};

   function automatic logic [KBPS_BITS-1:0] kbps_lookup(input logic [2:0] ver,
                                                        input logic [3:0] idx);
      logic [KBPS_BITS-1:0] v;
      case (ver)
         3'd1, 3'd2: v = KBPS_V2[idx];
         3'd3:       v = KBPS_V2L1[idx];
         3'd5:       v = KBPS_L3[idx];
         3'd6:       v = KBPS_L2[idx];
         3'd7:       v = KBPS_L1[idx];
         default:    v = KBPS_ZERO[idx];
      endcase
      return v;
   endfunction

   function automatic logic [RATE_BITS-1:0] hz_lookup(input logic [1:0] ri,
                                                      input logic mpeg1);
      logic [RATE_BITS-1:0] v;
      case (ri)
         2'd0:    v = mpeg1 ? 16'd44100 : 16'd22050;
         2'd1:    v = mpeg1 ? 16'd48000 : 16'd24000;
         2'd2:    v = mpeg1 ? 16'd32000 : 16'd16000;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mpeg_audio_frame_scanner.sv =====
// MPEG audio frame scanner: header search, frame skipping and stream summary.
//
// Usage: bytes of the stream arrive one per beat on the req_ channel; the byte
// flagged req_end_of_stream ends the stream and produces one beat on rsp_
// carrying frame count, average bitrate, length in seconds, channels, rate
// and the VBR flag. csr_write_data sets the file size; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// A plain byte (window shift or skipped byte) is accepted without a stall.
// A byte that completes a valid header stalls the req_ channel while the
// single shared restoring divider computes the frame length.
// The last byte also runs the divider for average bitrate, then length, and
// then loads the output register, after any frame length division it needs.
// The result sits in an output register; the next byte is taken while it
// waits, and only a further end-of-stream result stalls until rsp_ready.
// Reset (synchronous) clears all counters, the window, the skip count and
// the stop flag; file size returns to 0.
`default_nettype none
module mpeg_audio_frame_scanner
   import mafs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [SIZE_BITS-1:0]      csr_write_data,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_end_of_stream,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [OUT_COUNT_BITS-1:0]      rsp_frame_count,
   output logic [BITRATE_BITS-1:0]        rsp_average_bitrate,
   output logic [SIZE_BITS-1:0]           rsp_length_seconds,
   output logic [1:0]                     rsp_channel_count,
   output logic [RATE_BITS-1:0]           rsp_sample_rate,
   output logic                           rsp_variable_bitrate
);

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0]        file_size_ff;
   logic [31:0]                 window_ff;
   logic [2:0]                  fill_ff;
   logic [SKIP_BITS-1:0]        skip_ff;
   logic [FRAME_COUNT_BITS-1:0] frames_ff;
   logic [SUM_BITS-1:0]         sum_ff;
   logic [BITRATE_BITS-1:0]     prev_bps_ff;
   logic [1:0]                  channels_ff;
   logic [RATE_BITS-1:0]        rate_ff;
   logic                        vbr_ff;
   logic                        stopped_ff;
   logic                        eos_ff;
   logic                        pad_ff;
   logic [BITRATE_BITS-1:0]     avg_ff;
   logic                        rsp_valid_ff;

   logic [DVD_BITS-1:0]         dvd_ff;
   logic [DVS_BITS-1:0]         rem_ff;
   logic [DVS_BITS-1:0]         dvs_ff;
   logic [CNT_BITS-1:0]         cnt_ff;

   // control decode
   logic accept, div_step, load_fdiv, load_avg, load_len, emit;

   logic [31:0]                 win_in;
   logic [2:0]                  fill_in;
   logic                        scan_byte, sync_hit, hdr_bad, hdr_ok;
   logic [3:0]                  bri;
   logic [1:0]                  ri;
   logic [KBPS_BITS-1:0]        kbps;
   logic [RATE_BITS-1:0]        rate_hz;
   logic [BITRATE_BITS-1:0]     rate_bps;
   logic [DVD_BITS-1:0]         frame_dvd;
   logic                        frames_full;

   logic [DVS_BITS:0]           trial;
   logic                        ge;
   logic [DVS_BITS-1:0]         rem_nx;
   logic [DVD_BITS-1:0]         quo_nx;
   logic                        div_last;
   logic [BITRATE_BITS-1:0]     avg_nx;
   logic [BITRATE_BITS-1:0]     bps_nx;
   logic [SKIP_BITS-1:0]        skip_nx;
   logic [31:0]                 fc_wide;

   assign accept = req_valid && req_ready;

   // header decode on the window as it will be after this byte
   always_comb begin
      win_in    = {window_ff[23:0], req_data_byte};
      fill_in   = (fill_ff < 3'd4) ? fill_ff + 3'd1 : fill_ff;
      scan_byte = accept && !stopped_ff && (skip_ff == '0);
      sync_hit  = scan_byte && (fill_in == 3'd4) && (win_in[31:20] == SYNC_MARK);
      bri       = win_in[15:12];
      ri        = win_in[11:10];
      hdr_bad   = (win_in[18:17] == LAYER_NONE) || (bri == BRI_BAD) ||
                  (bri == BRI_FREE) || (ri == RI_BAD);
      hdr_ok    = sync_hit && !hdr_bad;
      kbps      = kbps_lookup(win_in[19:17], bri);
      rate_hz   = hz_lookup(ri, win_in[19]);
      rate_bps  = BITRATE_BITS'(BITRATE_BITS'(kbps) * BITRATE_BITS'(BPS_SCALE));
      frame_dvd = DVD_BITS'(kbps) * DVD_BITS'(FRAME_BYTES_SCALE);
      frames_full = (frames_ff == '1);
   end

   // shared restoring divider, one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, dvd_ff[DVD_BITS-1]};
      ge       = (trial >= {1'b0, dvs_ff});
      rem_nx   = ge ? DVS_BITS'(trial - {1'b0, dvs_ff}) : trial[DVS_BITS-1:0];
      quo_nx   = {dvd_ff[DVD_BITS-2:0], ge};
      div_last = (cnt_ff == CNT_BITS'(DVD_BITS - 1));
      avg_nx   = (frames_ff == '0) ? '0 : quo_nx[BITRATE_BITS-1:0];
      bps_nx   = ((avg_nx >> 3) == '0) ? BITRATE_BITS'(1) : (avg_nx >> 3);
      skip_nx  = quo_nx[SKIP_BITS-1:0] + SKIP_BITS'(pad_ff) - SKIP_BITS'(4);
      fc_wide  = 32'(frames_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (hdr_ok)
                  state_in = ST_FDIV;
               else if (req_end_of_stream)
                  state_in = ST_AVG;
            end
         end
         ST_FDIV: begin
            if (div_last)
               state_in = eos_ff ? ST_AVG : ST_IDLE;
         end
         ST_AVG: begin
            if (div_last)
               state_in = ST_LEN;
         end
         ST_LEN: begin
            if (div_last)
               state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_step  = 1'b0;
      load_fdiv = 1'b0;
      load_avg  = 1'b0;
      load_len  = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            load_fdiv = req_valid && hdr_ok;
            load_avg  = req_valid && !hdr_ok && req_end_of_stream;
         end
         ST_FDIV: begin
            div_step = 1'b1;
            load_avg = div_last && eos_ff;
         end
         ST_AVG: begin
            div_step = 1'b1;
            load_len = div_last;
         end
         ST_LEN: begin
            div_step = 1'b1;
         end
         ST_EMIT: begin
            emit = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         file_size_ff <= '0;
         window_ff    <= '0;
         fill_ff      <= '0;
         skip_ff      <= '0;
         frames_ff    <= '0;
         sum_ff       <= '0;
         prev_bps_ff  <= '0;
         channels_ff  <= '0;
         rate_ff      <= '0;
         vbr_ff       <= 1'b0;
         stopped_ff   <= 1'b0;
         eos_ff       <= 1'b0;
         pad_ff       <= 1'b0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable)
            file_size_ff <= csr_write_data;
         if (accept)
            eos_ff <= req_end_of_stream;

         if (accept && !stopped_ff) begin
            if (skip_ff != '0) begin
               skip_ff <= skip_ff - SKIP_BITS'(1);
            end else begin
               window_ff <= win_in;
               fill_ff   <= sync_hit ? 3'd0 : fill_in;
            end
         end

         if (sync_hit && hdr_bad)
            stopped_ff <= 1'b1;

         if (hdr_ok) begin
            if (prev_bps_ff != '0 && rate_bps != prev_bps_ff)
               vbr_ff <= 1'b1;
            prev_bps_ff <= rate_bps;
            channels_ff <= (win_in[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
            rate_ff     <= rate_hz;
            pad_ff      <= win_in[9];
            if (!frames_full) begin
               frames_ff <= frames_ff + FRAME_COUNT_BITS'(1);
               sum_ff    <= sum_ff + SUM_BITS'(rate_bps);
            end
         end

         if (state_ff == ST_FDIV && div_last)
            skip_ff <= skip_nx;
         if (state_ff == ST_AVG && div_last)
            avg_ff <= avg_nx;

         if (load_fdiv || load_avg || load_len)
            cnt_ff <= '0;
         else if (div_step)
            cnt_ff <= cnt_ff + CNT_BITS'(1);

         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // divider datapath and result register
   always_ff @(posedge clock) begin
      if (load_fdiv) begin
         dvd_ff <= frame_dvd;
         rem_ff <= '0;
         dvs_ff <= DVS_BITS'(rate_hz);
      end else if (load_avg) begin
         dvd_ff <= DVD_BITS'(sum_ff);
         rem_ff <= '0;
         dvs_ff <= DVS_BITS'(frames_ff);
      end else if (load_len) begin
         dvd_ff <= DVD_BITS'(file_size_ff);
         rem_ff <= '0;
         dvs_ff <= DVS_BITS'(bps_nx);
      end else if (div_step) begin
         dvd_ff <= quo_nx;
         rem_ff <= rem_nx;
      end

      if (emit) begin
         rsp_frame_count      <= (fc_wide > 32'hFFFFFF) ? '1 : fc_wide[OUT_COUNT_BITS-1:0];
         rsp_average_bitrate  <= avg_ff;
         rsp_length_seconds   <= dvd_ff[SIZE_BITS-1:0];
         rsp_channel_count    <= channels_ff;
         rsp_sample_rate      <= rate_ff;
         rsp_variable_bitrate <= vbr_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // assertions
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(stopped_ff) && !$past(reset) |-> stopped_ff)
      else $error("scan stop flag cleared without reset");

   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      accept && !stopped_ff && skip_ff != '0 |=> skip_ff == $past(skip_ff) - SKIP_BITS'(1))
      else $error("skipped byte did not decrement the skip count");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside the emit step");

   a_header_divides: assert property (@(posedge clock) disable iff (reset)
      accept && hdr_ok |=> state_ff == ST_FDIV && cnt_ff == '0)
      else $error("valid header did not start the frame length division");

endmodule
`default_nettype wire
